// ===== sv/ptab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptab_pkg: shared types and constants of the peer table
// Entry layout, event codes and action codes used by the cfg, engine and top-level files.
// ----------------------------------------------------------------------------
package ptab_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam logic [63:0] EXPIRY_RESET = 64'd1000000;
    localparam logic [7:0]  SERIAL_KIND  = 8'd0;

    typedef enum logic [1:0] {
        ACT_ANNOUNCE = 2'd0,
        ACT_SERIAL   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_QUERY    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EV_APPEARED    = 3'd0,
        EV_RESTARTED   = 3'd1,
        EV_DISAPPEARED = 3'd2,
        EV_QUERY       = 3'd3,
        EV_FULL        = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]  kind;
        logic [31:0] session;
        logic [15:0] tport;
        logic [15:0] cport;
        logic [63:0] seen;
        logic        serial;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

// ===== sv/ptab_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptab_in_if / ptab_out_if: valid/ready channels of the peer table
// One transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptab_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        packet_ok;
    logic [7:0]  kind;
    logic [31:0] session_id;
    logic [15:0] telemetry_port;
    logic [15:0] command_port;
    logic [63:0] now_us;
    modport source (output valid, action, packet_ok, kind, session_id, telemetry_port,
                    command_port, now_us, input ready);
    modport sink   (input valid, action, packet_ok, kind, session_id, telemetry_port,
                    command_port, now_us, output ready);
endinterface

interface ptab_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  peer_kind;
    logic [31:0] peer_session;
    logic [15:0] peer_telemetry_port;
    logic [15:0] peer_command_port;
    logic [63:0] peer_last_seen;
    logic        peer_serial;
    logic [31:0] reject_total;
    logic        last_of_run;
    modport source (output valid, event_res, peer_kind, peer_session, peer_telemetry_port,
                    peer_command_port, peer_last_seen, peer_serial, reject_total,
                    last_of_run, input ready);
    modport sink   (input valid, event_res, peer_kind, peer_session, peer_telemetry_port,
                    peer_command_port, peer_last_seen, peer_serial, reject_total,
                    last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/ptab_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptab_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ptab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/ptab_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptab_cfg: APB register file of the peer table
// Holds expiry_time at offset 0; reads there return it, other offsets read zero.
// ----------------------------------------------------------------------------
module ptab_cfg (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] o_expiry
);
    logic [63:0] r_expiry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= ptab_pkg::EXPIRY_RESET;
        end else if (psel && penable && pwrite && paddr == 4'd0) begin
            r_expiry <= pwdata;
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr == 4'd0) ? r_expiry : 64'd0;
    assign o_expiry = r_expiry;
endmodule
`default_nettype wire

// ===== sv/ptab_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptab_engine: sequencer of the peer table
// Scans the entry RAM one entry at a time (S_READ, then S_CHECK) for search, query and compaction.
// ----------------------------------------------------------------------------
module ptab_engine #(
    parameter int TABLE_DEPTH = ptab_pkg::TABLE_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire   [63:0] i_expiry,
    ptab_in_if.sink      in_ch,
    ptab_out_if.source   out_ch
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RD = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_WRITE, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0]  r_act;
    ptab_pkg::t_entry r_cand;
    logic [63:0] r_now;
    logic [CW-1:0] r_count, r_rd, r_wr;
    logic [31:0] r_rej;
    logic [4:0]  r_nres;
    logic        r_found;

    // RAM
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    ptab_pkg::t_entry w_wdata, w_rdata;
    logic [ptab_pkg::ENTRY_W-1:0] w_rbits;

    ptab_ram #(.WIDTH(ptab_pkg::ENTRY_W), .DEPTH(RD)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rbits)
    );
    assign w_rdata = ptab_pkg::t_entry'(w_rbits);

    // output register
    logic        r_ov;
    logic [2:0]  r_ev;
    ptab_pkg::t_entry r_oe;
    logic        r_olast;
    logic [31:0] r_orej;

    logic w_ofree;
    assign w_ofree = !r_ov || out_ch.ready;

    logic w_match, w_qhit, w_stale, w_restart;
    assign w_match = w_rdata.kind == r_cand.kind && w_rdata.tport == r_cand.tport
                     && w_rdata.cport == r_cand.cport;
    assign w_qhit  = w_rdata.kind == r_cand.kind && w_rdata.cport != 16'd0;
    assign w_stale = r_now >= w_rdata.seen && (r_now - w_rdata.seen) >= i_expiry;
    assign w_restart = r_cand.session != 32'd0 && w_rdata.session != r_cand.session;

    logic w_more;
    assign w_more = (r_rd + CW'(1)) < r_count;

    // a stale entry is held in r_cand until the next stale one shows it was not the last
    logic w_tick_emit, w_oload;
    assign w_tick_emit = r_state == S_CHECK && r_act == ptab_pkg::ACT_TICK && w_ofree
                         && w_stale && r_nres < 5'(ptab_pkg::MAX_RESULTS);
    assign w_oload = (w_tick_emit && r_nres != 5'd0)
                     || (r_state == S_OUT && w_ofree
                         && (r_act != ptab_pkg::ACT_TICK || r_nres != 5'd0));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr[AW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_rd[AW-1:0];
        if (r_state == S_WRITE) begin
            w_we    = 1'b1;
            w_wdata = r_cand;
            w_waddr = r_rd[AW-1:0];
        end else if (r_state == S_CHECK && r_act == ptab_pkg::ACT_TICK && w_ofree
                     && !(w_stale && r_nres < 5'(ptab_pkg::MAX_RESULTS)) && r_wr != r_rd) begin
            w_we = 1'b1;
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rej   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ov   <= 1'b1;
                r_orej <= r_rej;
            end else if (out_ch.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_act <= in_ch.action;
                        r_now <= in_ch.now_us;
                        r_rd  <= '0;
                        r_wr  <= '0;
                        r_nres <= '0;
                        r_found <= 1'b0;
                        if (in_ch.action == ptab_pkg::ACT_SERIAL) begin
                            r_cand <= '{kind: ptab_pkg::SERIAL_KIND, session: 32'd0,
                                        tport: 16'd0, cport: 16'd0, seen: in_ch.now_us,
                                        serial: 1'b1};
                        end else begin
                            r_cand <= '{kind: in_ch.kind, session: in_ch.session_id,
                                        tport: in_ch.telemetry_port,
                                        cport: in_ch.command_port,
                                        seen: in_ch.now_us, serial: 1'b0};
                        end
                        if (in_ch.action == ptab_pkg::ACT_ANNOUNCE && !in_ch.packet_ok) begin
                            r_rej <= r_rej + 32'd1;
                        end else if (r_count == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    unique case (r_act)
                        ptab_pkg::ACT_TICK: begin
                            if (w_ofree) begin
                                if (w_stale && r_nres < 5'(ptab_pkg::MAX_RESULTS)) begin
                                    // release the held entry, hold this one
                                    r_ev    <= ptab_pkg::EV_DISAPPEARED;
                                    r_oe    <= r_cand;
                                    r_olast <= 1'b0;
                                    r_cand  <= w_rdata;
                                    r_nres  <= r_nres + 5'd1;
                                end else begin
                                    r_wr <= r_wr + CW'(1);
                                end
                                r_rd <= r_rd + CW'(1);
                                if (!w_more) r_state <= S_OUT;
                                else r_state <= S_READ;
                            end
                        end
                        ptab_pkg::ACT_QUERY: begin
                            if (w_qhit) begin
                                r_found <= 1'b1;
                                r_cand.cport <= w_rdata.cport;
                                r_state <= S_OUT;
                            end else if (!w_more) begin
                                r_state <= S_OUT;
                            end else begin
                                r_rd <= r_rd + CW'(1);
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                            if (w_match) begin
                                r_found <= 1'b1;
                                r_cand.kind  <= w_rdata.kind;
                                r_cand.tport <= w_rdata.tport;
                                r_cand.cport <= w_rdata.cport;
                                r_nres <= {4'd0, w_restart};
                                r_state <= S_WRITE;
                            end else if (!w_more) begin
                                r_state <= S_OUT;
                            end else begin
                                r_rd <= r_rd + CW'(1);
                                r_state <= S_READ;
                            end
                        end
                    endcase
                end
                S_WRITE: begin
                    // refresh or new entry written; report restart if any
                    if (r_nres == 5'd0 || r_found == 1'b0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_ofree) begin
                        r_olast <= 1'b1;
                        if (r_act == ptab_pkg::ACT_TICK) begin
                            r_state <= S_IDLE;
                            r_count <= r_wr;
                            r_ev    <= ptab_pkg::EV_DISAPPEARED;
                            r_oe    <= r_cand;
                        end else if (r_act == ptab_pkg::ACT_QUERY) begin
                            r_state <= S_IDLE;
                            r_ev <= ptab_pkg::EV_QUERY;
                            r_oe <= '{kind: r_cand.kind, session: 32'd0, tport: 16'd0,
                                      cport: r_found ? r_cand.cport : 16'd0,
                                      seen: 64'd0, serial: 1'b0};
                        end else if (r_found) begin
                            r_state <= S_IDLE;
                            r_ev <= ptab_pkg::EV_RESTARTED;
                            r_oe <= r_cand;
                        end else if (r_count >= CW'(TABLE_DEPTH)) begin
                            r_state <= S_IDLE;
                            r_ev <= ptab_pkg::EV_FULL;
                            r_oe <= r_cand;
                        end else begin
                            r_ev <= ptab_pkg::EV_APPEARED;
                            r_oe <= r_cand;
                            r_count <= r_count + CW'(1);
                            r_rd <= r_count;
                            r_state <= S_WRITE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid               = r_ov;
    assign out_ch.event_res           = r_ev;
    assign out_ch.peer_kind           = r_oe.kind;
    assign out_ch.peer_session        = r_oe.session;
    assign out_ch.peer_telemetry_port = r_oe.tport;
    assign out_ch.peer_command_port   = r_oe.cport;
    assign out_ch.peer_last_seen      = r_oe.seen;
    assign out_ch.peer_serial         = r_oe.serial;
    assign out_ch.reject_total        = r_orej;
    assign out_ch.last_of_run         = r_olast;
endmodule
`default_nettype wire

// ===== sv/peer_table_with_aging.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peer_table_with_aging: learning table of peers with aging
// Top level: APB register file and the scan engine over one entry RAM.
// ----------------------------------------------------------------------------
// The table lives in one RAM with a registered read; the engine walks it one
// entry at a time, and a tick scan waits while the result side stalls. A rejected
// announce only counts up the reject total and stays idle. No clearing pass is
// needed after reset. Results leave through a single output register.
module peer_table_with_aging #(
    parameter int TABLE_DEPTH = ptab_pkg::TABLE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ptab_in_if.sink     in_ch,
    ptab_out_if.source  out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] w_expiry;

    ptab_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_expiry(w_expiry)
    );

    ptab_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_expiry(w_expiry),
        .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule
`default_nettype wire
